FILE: rtl/core/bbl_pkg.sv
// Shared types, constants and the control program of the biquad low-pass filter.
package bbl_pkg;

   // Fixed field and register widths
   localparam int COEF_B0_BITS  = 17;
   localparam int COEF_A_BITS   = 18;
   localparam int DELAY_BITS    = 32;
   localparam int SUM_BITS      = DELAY_BITS + 2;
   localparam int PROD_BITS     = COEF_A_BITS + SUM_BITS;
   localparam int CSR_DATA_BITS = 18;
   localparam int CSR_ADDR_BITS = 2;
   localparam int STEP_BITS     = 3;

   // Configuration register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_B0       = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A1       = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A2       = 2'd3;

   typedef logic [STEP_BITS-1:0] step_type;

   // Program addresses
   localparam step_type STEP_WAIT = 3'd0;
   localparam step_type STEP_MA1  = 3'd1;
   localparam step_type STEP_MA2  = 3'd2;
   localparam step_type STEP_SUB  = 3'd3;
   localparam step_type STEP_W0   = 3'd4;
   localparam step_type STEP_MB0  = 3'd5;
   localparam step_type STEP_OUT  = 3'd6;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_A1W1,
      MUL_A2W2,
      MUL_B0S
   } mul_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ACCEPT,
      JMP_OUT,
      JMP_START
   } jump_type;

   // One control word of the program
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_sub;
      logic        w0_load;
      logic        out_load;
      jump_type    jump;
   } ucode_type;

   // Strobes from the sequencer to the datapath
   typedef struct packed {
      logic        acc_load;
      mul_sel_type mul_sel;
      logic        acc_sub;
      logic        w0_load;
      logic        out_load;
   } ctrl_type;

   // Control store: one word per program step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '{mul_sel: MUL_NONE, acc_sub: 1'b0, w0_load: 1'b0, out_load: 1'b0,
               jump: JMP_START};
      case (step)
         STEP_WAIT: word.jump = JMP_ACCEPT;
         STEP_MA1: begin
            word.mul_sel = MUL_A1W1;
            word.jump    = JMP_NEXT;
         end
         STEP_MA2: begin
            word.mul_sel = MUL_A2W2;
            word.acc_sub = 1'b1;
            word.jump    = JMP_NEXT;
         end
         STEP_SUB: begin
            word.acc_sub = 1'b1;
            word.jump    = JMP_NEXT;
         end
         STEP_W0: begin
            word.w0_load = 1'b1;
            word.jump    = JMP_NEXT;
         end
         STEP_MB0: begin
            word.mul_sel = MUL_B0S;
            word.jump    = JMP_NEXT;
         end
         STEP_OUT: begin
            word.out_load = 1'b1;
            word.jump     = JMP_OUT;
         end
         default: word.jump = JMP_START;
      endcase
      return word;
   endfunction

endpackage

FILE: rtl/core/bbl_sequencer.sv
// Step counter and control-store sequencer of the biquad low-pass filter.
module bbl_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              filter_enable,
   input  logic              out_blocked,
   output logic              req_stall,
   output bbl_pkg::ctrl_type ctrl
);
   import bbl_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      accept;
   logic      out_fire;

   // Decode the current control word
   assign word      = ucode_rom(step_ff);
   assign req_stall = (word.jump != JMP_ACCEPT);
   assign accept    = req_valid && !req_stall;
   assign out_fire  = word.out_load && !out_blocked;

   assign ctrl.acc_load = accept;
   assign ctrl.mul_sel  = word.mul_sel;
   assign ctrl.acc_sub  = word.acc_sub;
   assign ctrl.w0_load  = word.w0_load;
   assign ctrl.out_load = out_fire;

   // Pick the next step: advance, branch on accept, or hold on a stalled result
   always_comb begin
      step_in = step_ff;
      case (word.jump)
         JMP_NEXT:   step_in = step_ff + step_type'(1);
         JMP_ACCEPT: begin
            if (accept) begin
               step_in = filter_enable ? STEP_MA1 : STEP_OUT;
            end
         end
         JMP_OUT: begin
            if (!out_blocked) begin
               step_in = STEP_WAIT;
            end
         end
         default:    step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_only_waiting: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> step_ff == STEP_WAIT)
      else $error("request taken outside the wait step");
   a_filter_branch: assert property (@(posedge clock) disable iff (reset)
      accept && filter_enable |=> step_ff == STEP_MA1)
      else $error("filtered request did not start the program");
   a_bypass_branch: assert property (@(posedge clock) disable iff (reset)
      accept && !filter_enable |=> step_ff == STEP_OUT)
      else $error("bypassed request did not go to the output step");
   a_out_returns: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> step_ff == STEP_WAIT)
      else $error("sequencer did not return after the output step");
`endif

endmodule

FILE: rtl/core/bbl_datapath.sv
// Configuration registers, shared multiplier, accumulator, delay terms and result register.
module bbl_datapath #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bbl_pkg::ctrl_type                    ctrl,
   input  logic                                 csr_write_enable,
   input  logic [bbl_pkg::CSR_ADDR_BITS-1:0]    csr_index,
   input  logic [bbl_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic                                 rsp_stall,
   output logic                                 filter_enable,
   output logic                                 out_blocked,
   output logic                                 rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   output logic                                 rsp_clipped
);
   import bbl_pkg::*;

   localparam int X_BITS   = SAMPLE_BITS + COEF_FRAC_BITS;
   localparam int ACC_BITS = ((X_BITS > COEF_A_BITS + DELAY_BITS) ?
                              X_BITS : COEF_A_BITS + DELAY_BITS) + 2;
   localparam logic signed [ACC_BITS-1:0]  ACC_HALF  = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [DELAY_BITS-1:0] DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
   localparam logic signed [DELAY_BITS-1:0] DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                            enable_ff;
   logic [COEF_B0_BITS-1:0]         coef_b0_ff;
   logic signed [COEF_A_BITS-1:0]   coef_a1_ff;
   logic signed [COEF_A_BITS-1:0]   coef_a2_ff;
   logic signed [DELAY_BITS-1:0]    delay_one_ff;
   logic signed [DELAY_BITS-1:0]    delay_two_ff;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_out_ff;
   logic                            rsp_clipped_ff;

   logic signed [SAMPLE_BITS-1:0]   x_ff;
   logic signed [ACC_BITS-1:0]      acc_ff;
   logic signed [ACC_BITS-1:0]      acc_in;
   logic signed [PROD_BITS-1:0]     prod_ff;
   logic signed [PROD_BITS-1:0]     prod_in;
   logic signed [COEF_A_BITS-1:0]   mul_a;
   logic signed [SUM_BITS-1:0]      mul_b;
   logic signed [DELAY_BITS-1:0]    w0_ff;
   logic signed [DELAY_BITS-1:0]    w0_in;
   logic signed [SUM_BITS-1:0]      s_ff;
   logic signed [SUM_BITS-1:0]      s_in;
   logic                            clip_ff;
   logic                            w0_ovf;

   logic signed [ACC_BITS-1:0]      acc_shift;
   logic [ACC_BITS-DELAY_BITS:0]    acc_top;
   logic signed [PROD_BITS-1:0]     y_round;
   logic signed [PROD_BITS-1:0]     y_shift;
   logic [PROD_BITS-SAMPLE_BITS:0]  y_top;
   logic signed [SAMPLE_BITS-1:0]   y_sat;
   logic                            y_ovf;

   assign filter_enable  = enable_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;
   assign out_blocked    = rsp_valid_ff && rsp_stall;

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_sel)
         MUL_A1W1: begin
            mul_a = coef_a1_ff;
            mul_b = SUM_BITS'(delay_one_ff);
         end
         MUL_A2W2: begin
            mul_a = coef_a2_ff;
            mul_b = SUM_BITS'(delay_two_ff);
         end
         MUL_B0S: begin
            mul_a = signed'({1'b0, coef_b0_ff});
            mul_b = s_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // Load the scaled sample with rounding offset, or subtract a feedback product
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = (ACC_BITS'(req_sample_in) <<< COEF_FRAC_BITS) + ACC_HALF;
      end else if (ctrl.acc_sub) begin
         acc_in = acc_ff - ACC_BITS'(prod_ff);
      end
   end

   // Round and clamp the new delay term, then form the feed-forward sum
   always_comb begin
      acc_shift = acc_ff >>> COEF_FRAC_BITS;
      acc_top   = acc_shift[ACC_BITS-1:DELAY_BITS-1];
      w0_ovf    = !((&acc_top) || !(|acc_top));
      if (!w0_ovf) begin
         w0_in = acc_shift[DELAY_BITS-1:0];
      end else if (acc_shift[ACC_BITS-1]) begin
         w0_in = DELAY_MIN;
      end else begin
         w0_in = DELAY_MAX;
      end
      s_in = SUM_BITS'(w0_in) + (SUM_BITS'(delay_one_ff) <<< 1) + SUM_BITS'(delay_two_ff);
   end

   // Round and clamp the output sample
   always_comb begin
      y_round = prod_ff + PROD_HALF;
      y_shift = y_round >>> COEF_FRAC_BITS;
      y_top   = y_shift[PROD_BITS-1:SAMPLE_BITS-1];
      y_ovf   = !((&y_top) || !(|y_top));
      if (!y_ovf) begin
         y_sat = y_shift[SAMPLE_BITS-1:0];
      end else if (y_shift[PROD_BITS-1]) begin
         y_sat = SAMPLE_MIN;
      end else begin
         y_sat = SAMPLE_MAX;
      end
   end

   // Working registers of the program
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.acc_load) begin
         x_ff <= req_sample_in;
      end
      if (ctrl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (ctrl.w0_load) begin
         w0_ff   <= w0_in;
         s_ff    <= s_in;
         clip_ff <= w0_ovf;
      end
   end

   // Result payload: filtered sample or the bypassed input
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         if (enable_ff) begin
            rsp_sample_out_ff <= y_sat;
            rsp_clipped_ff    <= clip_ff || y_ovf;
         end else begin
            rsp_sample_out_ff <= x_ff;
            rsp_clipped_ff    <= 1'b0;
         end
      end
   end

   // Configuration, delay terms and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         coef_b0_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FILTER_ENABLE: enable_ff  <= csr_write_data[0];
               CSR_COEF_B0:       coef_b0_ff <= csr_write_data[COEF_B0_BITS-1:0];
               CSR_COEF_A1:       coef_a1_ff <= signed'(csr_write_data[COEF_A_BITS-1:0]);
               CSR_COEF_A2:       coef_a2_ff <= signed'(csr_write_data[COEF_A_BITS-1:0]);
               default:           enable_ff  <= enable_ff;
            endcase
            delay_one_ff <= '0;
            delay_two_ff <= '0;
         end else if (ctrl.out_load && enable_ff) begin
            delay_two_ff <= delay_one_ff;
            delay_one_ff <= w0_ff;
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_config_clears_state: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> delay_one_ff == '0 && delay_two_ff == '0)
      else $error("configuration write left delay state behind");
   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/core/butterworth_biquad_lowpass_top.sv
// Top level of the second-order Butterworth low-pass biquad filter.
//
// Requests arrive on req_valid/req_stall with one signed sample in req_sample_in;
// each produces exactly one result on rsp_valid/rsp_stall carrying rsp_sample_out
// and rsp_clipped. A side holding valid with stall low completes a transfer.
// Coefficients and the enable are written through csr_write_enable/csr_index/
// csr_write_data; the user must write them only while no request is in progress,
// which the block itself does not enforce. Every write clears both delay terms.
// One shared 18 x 34 bit multiplier runs a seven-step control program: the two
// feedback products, rounding and clamping of the new delay term, and the
// feed-forward product. A request is taken only in the wait step, so the block
// takes no new request before it is through with the previous one.
// With the filter disabled the sample is passed through to the output step.
// Reset clears the configuration to zero (filter disabled), the delay terms and
// the result valid. While the receiver stalls, the result register holds; the next
// request is still taken and worked on, and it waits at the output step until the
// register frees.
module butterworth_biquad_lowpass_top #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample_out,
   output logic                              rsp_clipped,
   input  logic                              csr_write_enable,
   input  logic [bbl_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [bbl_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import bbl_pkg::*;

   ctrl_type ctrl;
   logic     filter_enable;
   logic     out_blocked;

   bbl_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .filter_enable (filter_enable),
      .out_blocked   (out_blocked),
      .req_stall     (req_stall),
      .ctrl          (ctrl)
   );

   bbl_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample_in    (req_sample_in),
      .rsp_stall        (rsp_stall),
      .filter_enable    (filter_enable),
      .out_blocked      (out_blocked),
      .rsp_valid        (rsp_valid),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_clipped      (rsp_clipped)
   );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Butterworth biquad low-pass filter top level.
module tb;
   import bbl_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int FRAC_W        = 16;
   localparam int WAIT_MAX      = 12;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int REPORT_MAX    = 10;

   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_W - 1);
   localparam longint W_MAX      = (longint'(1) <<< (DELAY_BITS - 1)) - 1;
   localparam longint W_MIN      = -(longint'(1) <<< (DELAY_BITS - 1));
   localparam longint Y_MAX      = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint Y_MIN      = -(longint'(1) <<< (SAMPLE_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } filter_result_type;

   typedef enum int {
      SET_BYPASS,
      SET_BUTTERWORTH,
      SET_EXTREME,
      SET_RANDOM
   } setting_kind_type;

   // Butterworth sections for cutoffs of 0.1, 0.25, 0.02 and 0.4 of the sample rate
   int bw_b0[4] = '{4421, 19195, 237, 41874};
   int bw_a1[4] = '{-74907, 0, -119450, 74907};
   int bw_a2[4] = '{27053, 11244, 54863, 27054};

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_clipped;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]   csr_write_data   = '0;

   // Filter model: configuration and the two delay terms
   bit     model_enable;
   longint model_b0;
   longint model_a1;
   longint model_a2;
   longint model_w1;
   longint model_w2;

   logic signed [SAMPLE_W-1:0] samples_to_send[$];
   filter_result_type          expected_outputs[$];
   filter_result_type          want;

   int unsigned samples_queued;
   int unsigned samples_offered;
   int unsigned samples_accepted;
   int unsigned results_seen;
   int unsigned results_drawn;
   int unsigned error_count;
   int unsigned bypass_count;
   int unsigned clipped_count;
   int unsigned registers_written;
   int unsigned settings_used;
   int unsigned cycle_count;
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned hold_left;
   int unsigned holds_done;
   int unsigned next_hold_at = 300;
   bit          sender_idle_on   = 1'b1;
   bit          receiver_idle_on = 1'b1;

   butterworth_biquad_lowpass_top #(
      .SAMPLE_BITS   (SAMPLE_W),
      .COEF_FRAC_BITS(FRAC_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_clipped     (rsp_clipped),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Compute the filter output for one sample and advance the delay line
   function automatic filter_result_type biquad_step(input logic signed [SAMPLE_W-1:0] x);
      filter_result_type res;
      longint            acc;
      longint            w0;
      longint            s;
      longint            y;
      res.clipped = 1'b0;
      if (!model_enable) begin
         res.sample = x;
         bypass_count++;
         return res;
      end
      acc = (longint'(x) <<< FRAC_W) - model_a1 * model_w1 - model_a2 * model_w2;
      w0 = (acc + ROUND_HALF) >>> FRAC_W;
      if (w0 > W_MAX) begin
         w0 = W_MAX;
         res.clipped = 1'b1;
      end else if (w0 < W_MIN) begin
         w0 = W_MIN;
         res.clipped = 1'b1;
      end
      s = w0 + 2 * model_w1 + model_w2;
      y = (model_b0 * s + ROUND_HALF) >>> FRAC_W;
      if (y > Y_MAX) begin
         y = Y_MAX;
         res.clipped = 1'b1;
      end else if (y < Y_MIN) begin
         y = Y_MIN;
         res.clipped = 1'b1;
      end
      model_w2 = model_w1;
      model_w1 = w0;
      res.sample = y[SAMPLE_W-1:0];
      return res;
   endfunction

   // Draw a random wait for the sender or the receiver; now and then switch idling off or on
   function automatic int unsigned draw_wait(inout bit idle_on);
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      return idle_on ? $urandom_range(0, WAIT_MAX) : 0;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_extreme();
      case ($urandom_range(0, 2))
         0: return 18'h20000;
         1: return 18'h1ffff;
         default: return '0;
      endcase
   endfunction

   function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] x);
      samples_to_send.push_back(x);
      samples_queued++;
   endfunction

   // Wait for every queued request to come back, then let the pipeline drain
   task automatic wait_idle();
      while (results_seen != samples_queued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; any write clears the delay line
   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      case (index)
         CSR_FILTER_ENABLE: model_enable = data[0];
         CSR_COEF_B0:       model_b0 = longint'(data[COEF_B0_BITS-1:0]);
         CSR_COEF_A1:       model_a1 = longint'($signed(data[COEF_A_BITS-1:0]));
         CSR_COEF_A2:       model_a2 = longint'($signed(data[COEF_A_BITS-1:0]));
         default: ;
      endcase
      model_w1 = 0;
      model_w2 = 0;
      registers_written++;
   endtask

   // Load a full setting once the block is idle, in a rotated register order
   task automatic apply_setting(input logic [CSR_DATA_BITS-1:0] en_data,
                                input logic [CSR_DATA_BITS-1:0] b0_data,
                                input logic [CSR_DATA_BITS-1:0] a1_data,
                                input logic [CSR_DATA_BITS-1:0] a2_data);
      logic [CSR_DATA_BITS-1:0] values[4];
      logic [CSR_ADDR_BITS-1:0] index;
      values[CSR_FILTER_ENABLE] = en_data;
      values[CSR_COEF_B0]       = b0_data;
      values[CSR_COEF_A1]       = a1_data;
      values[CSR_COEF_A2]       = a2_data;
      index = CSR_ADDR_BITS'($urandom);
      wait_idle();
      repeat (4) begin
         write_register(index, values[index]);
         index++;
      end
      // occasionally rewrite one register
      if ($urandom_range(0, 3) == 0) begin
         index = CSR_ADDR_BITS'($urandom);
         write_register(index, values[index]);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Drive requests from the pending sample queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || samples_accepted == samples_offered) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (samples_to_send.size() != 0) begin
            req_valid     <= 1'b1;
            req_sample_in <= samples_to_send.pop_front();
            samples_offered++;
            send_gap = draw_wait(sender_idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall results at random, and for long stretches while a hold-off runs
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (results_drawn != results_seen) begin
            results_drawn = results_seen;
            stall_left = draw_wait(receiver_idle_on);
         end
         rsp_stall <= (hold_left != 0) || (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Hold off the receiver twice in mid-stream so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_left != 0) begin
         hold_left--;
      end else if (holds_done < 2 && samples_offered >= next_hold_at) begin
         hold_left = 150 + $urandom_range(0, 100);
         holds_done++;
         next_hold_at += 700;
      end
   end

   // Check each result against the oldest prediction, then predict taken requests
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_outputs.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected result: sample_out %0d clipped %0b",
                        rsp_sample_out, rsp_clipped);
         end else begin
            want = expected_outputs.pop_front();
            if (want.clipped) clipped_count++;
            if (rsp_sample_out !== want.sample || rsp_clipped !== want.clipped) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display({"result %0d: sample_out expected %0d got %0d, ",
                            "clipped expected %0b got %0b"},
                           results_seen, $signed(want.sample), rsp_sample_out,
                           want.clipped, rsp_clipped);
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         expected_outputs.push_back(biquad_step(req_sample_in));
         samples_accepted++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("butterworth_biquad_lowpass_top test failed");
         $finish;
      end
   end

   initial begin
      logic signed [SAMPLE_W-1:0] level;
      logic signed [SAMPLE_W-1:0] x;
      logic [CSR_DATA_BITS-1:0]   en_d;
      logic [CSR_DATA_BITS-1:0]   b0_d;
      logic [CSR_DATA_BITS-1:0]   a1_d;
      logic [CSR_DATA_BITS-1:0]   a2_d;
      setting_kind_type           kind;
      int                         pick;
      int                         t;
      int                         phase_len;
      int unsigned                random_sent;
      int unsigned                phase;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // pass-through with the reset configuration
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      queue_sample(16'sh0000);
      queue_sample(16'shffff);

      // typical low-pass, enable written with all spare bits set
      apply_setting('1, 18'd4421, -18'sd74907, 18'd27053);
      repeat (3) queue_sample(16'sh7fff);
      repeat (2) queue_sample(16'sh8000);
      queue_sample(16'sh0001);
      queue_sample(16'shffff);

      // largest gain, oversized b0 write: the output saturates
      apply_setting(18'd1, '1, '0, '0);
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);

      // both feedback terms at the negative limit: the delay line runs away
      apply_setting(18'd1, 18'd1, 18'h20000, 18'h20000);
      repeat (12) queue_sample(16'sh7fff);

      // random settings, each followed by a stretch of step-like signal
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         kind = (phase < 4) ? setting_kind_type'(phase)
                            : setting_kind_type'($urandom_range(0, 3));
         en_d = CSR_DATA_BITS'($urandom);
         b0_d = CSR_DATA_BITS'($urandom);
         a1_d = CSR_DATA_BITS'($urandom);
         a2_d = CSR_DATA_BITS'($urandom);
         case (kind)
            SET_BYPASS: en_d[0] = 1'b0;
            SET_BUTTERWORTH: begin
               pick = $urandom_range(0, 3);
               en_d[0] = 1'b1;
               b0_d = CSR_DATA_BITS'(bw_b0[pick]);
               a1_d = CSR_DATA_BITS'(bw_a1[pick]);
               a2_d = CSR_DATA_BITS'(bw_a2[pick]);
            end
            SET_EXTREME: begin
               en_d[0] = 1'b1;
               b0_d[COEF_B0_BITS-1:0] = $urandom_range(0, 1) ? '1 : '0;
               a1_d = pick_extreme();
               a2_d = pick_extreme();
            end
            default: ;
         endcase
         apply_setting(en_d, b0_d, a1_d, a2_d);

         phase_len = $urandom_range(40, 220);
         level = SAMPLE_W'($urandom);
         repeat (phase_len) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end else if (pick < 4) begin
               x = SAMPLE_W'($urandom);
            end else begin
               // hold a level with small noise, jump to a new one now and then
               if (pick == 4) level = SAMPLE_W'($urandom);
               t = int'(level) + int'($urandom_range(0, 255)) - 128;
               if (t > 32767) t = 32767;
               else if (t < -32768) t = -32768;
               x = SAMPLE_W'(t);
            end
            queue_sample(x);
         end
         random_sent += phase_len;
         phase++;
      end

      wait_idle();
      $display("Covered %0d samples over %0d settings with %0d register writes.",
               samples_accepted, settings_used, registers_written);
      $display({"%0d results checked: %0d passed through, %0d clipped, ",
                "%0d errors, %0d left over."},
               results_seen, bypass_count, clipped_count, error_count,
               expected_outputs.size());
      if (error_count == 0 && expected_outputs.size() == 0)
         $display("butterworth_biquad_lowpass_top test passed");
      else
         $display("butterworth_biquad_lowpass_top test failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/bbl_pkg.sv
rtl/core/bbl_sequencer.sv
rtl/core/bbl_datapath.sv
rtl/core/butterworth_biquad_lowpass_top.sv
verif/tb.sv
